// ===== rtl/adaptive_hash_bucket_rate_limiter_defines.svh =====
// assertion macros shared by the rate limiter modules
`ifndef ADAPTIVE_HASH_BUCKET_RATE_LIMITER_DEFINES_SVH
`define ADAPTIVE_HASH_BUCKET_RATE_LIMITER_DEFINES_SVH

// condition holds at every edge out of reset
`define AHBRL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define AHBRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define AHBRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ahbrl_pkg.sv =====
// shared types, codes and constants of the rate limiter
package ahbrl_pkg;

  localparam int BUCKETS_DEFAULT = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int BUCKET_W        = 6;
  localparam int LEVEL_W         = 7;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int HASH_STEPS      = 4;
  localparam int MOD_DIGITS      = 8;

  localparam logic [31:0] HASH_SEED  = 32'd59123;
  localparam int          HASH_SHIFT = 5;

  // input command codes
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // verdict codes
  localparam logic [1:0] VERDICT_REPLY  = 2'd0;
  localparam logic [1:0] VERDICT_REJECT = 2'd1;
  localparam logic [1:0] VERDICT_DROP   = 2'd2;
  localparam logic [1:0] VERDICT_TICK   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_REQUEST_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SERVE_PUBLIC  = 2'd2;

  localparam logic [15:0] REQUEST_LIMIT_RESET = 16'd1000;
  localparam logic [15:0] WINDOW_LENGTH_RESET = 16'd60;
  localparam logic        SERVE_PUBLIC_RESET  = 1'b1;

  typedef struct packed {
    logic [15:0] request_limit;
    logic [15:0] window_length;
    logic        serve_public;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                command;
    logic                private_signed;
    logic [31:0]         current_time;
    logic [BUCKET_W-1:0] bucket;
  } entry_t;

  // one hash round: h * 33 + byte
  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
    return (h << HASH_SHIFT) + h + {24'd0, b};
  endfunction

endpackage

// ===== rtl/ahbrl_if.sv =====
// channel interfaces of the rate limiter

// request channel
interface ahbrl_in_if;
  import ahbrl_pkg::*;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] client_address;
  logic        private_signed;
  logic [31:0] current_time;

  modport source (output valid, command, client_address, private_signed, current_time,
                  input ready);
  modport sink (input valid, command, client_address, private_signed, current_time,
                output ready);
endinterface

// result channel
interface ahbrl_out_if;
  import ahbrl_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          verdict;
  logic [BUCKET_W-1:0] bucket_index;
  logic [LEVEL_W-1:0]  current_reject_level;
  logic [15:0]         window_count;
  logic [31:0]         accepted_count;
  logic [31:0]         rejected_count;

  modport source (output valid, verdict, bucket_index, current_reject_level, window_count,
                  accepted_count, rejected_count, input ready);
  modport sink (input valid, verdict, bucket_index, current_reject_level, window_count,
                accepted_count, rejected_count, output ready);
endinterface

// configuration write channel
interface ahbrl_cfg_if;
  import ahbrl_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/adaptive_hash_bucket_rate_limiter.sv =====
// Hash-bucket admission filter for public requests.
// Channels: req carries one item (a request or an idle tick) per handshake,
// res returns exactly one result item per accepted item, in order, and cfg
// writes request_limit (0), window_length (1) and serve_public (2); other
// indexes are ignored. cfg is always ready; the user must write it only
// while idle, as the block itself does not enforce this. The front hashes
// the address one byte a cycle and reduces it modulo BUCKETS four bits a
// cycle; ticks skip both. A two-entry queue feeds the back, which, when
// the window is tightened or relaxed, first finds the busiest or quietest
// bucket by walking the hit memory one entry a cycle. The front takes a
// new item only after handing the last one to the queue, while the back
// works on earlier items. Reset clears the queue, opens all buckets and
// zeroes every counter; hit counts clear at once through per-bucket valid
// bits. When res stalls, one result waits in the output register, the
// back holds its next result, and the queue and front keep accepting
// until full.
module adaptive_hash_bucket_rate_limiter import ahbrl_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  ahbrl_in_if.sink  req,
  ahbrl_out_if.source res,
  ahbrl_cfg_if.sink cfg
);

  cfg_t   cfg_regs;
  logic   push_valid;
  entry_t push_entry;
  logic   push_ready;
  logic   q_valid;
  entry_t q_entry;
  logic   q_pop;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.request_limit <= REQUEST_LIMIT_RESET;
      cfg_regs.window_length <= WINDOW_LENGTH_RESET;
      cfg_regs.serve_public  <= SERVE_PUBLIC_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_REQUEST_LIMIT: cfg_regs.request_limit <= cfg.data;
        REG_WINDOW_LENGTH: cfg_regs.window_length <= cfg.data;
        REG_SERVE_PUBLIC:  cfg_regs.serve_public  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  ahbrl_front #(.BUCKETS(BUCKETS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  ahbrl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .pop        (q_pop)
  );

  ahbrl_back #(.BUCKETS(BUCKETS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

// ===== rtl/ahbrl_front.sv =====
// front end: accepts items, hashes the client address and reduces it to a bucket
module ahbrl_front import ahbrl_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  ahbrl_in_if.sink req,
  output logic   push_valid,
  output entry_t push_entry,
  input  logic   push_ready
);

  localparam int BW = $clog2(BUCKETS);
  localparam logic [BW:0] MODULUS = (BW+1)'(BUCKETS);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_MOD  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]    state;
  logic [2:0]    cnt;
  logic [31:0]   h;
  logic [31:0]   addr;
  logic [BW-1:0] r;
  logic          cmd;
  logic          priv;
  logic [31:0]   now;

  // four restoring remainder steps, one per hash bit
  function automatic logic [BW-1:0] mod_digit(input logic [BW-1:0] rin, input logic [3:0] dig);
    logic [BW:0]   t;
    logic [BW-1:0] acc;
    acc = rin;
    for (int k = 3; k >= 0; k--) begin
      t = {acc, dig[k]};
      if (t >= MODULUS) t = t - MODULUS;
      acc = t[BW-1:0];
    end
    return acc;
  endfunction

  assign req.ready  = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_entry = '{command: cmd, private_signed: priv, current_time: now,
                        bucket: BUCKET_W'(r)};

  // sequencer: accept, hash one byte a cycle, reduce four bits a cycle, hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (req.valid) begin
            cmd   <= req.command;
            priv  <= req.private_signed;
            now   <= req.current_time;
            addr  <= req.client_address;
            h     <= HASH_SEED;
            r     <= '0;
            cnt   <= '0;
            state <= (req.command == CMD_TICK) ? F_PUSH : F_HASH;
          end
        end
        F_HASH: begin
          h    <= hash_step(h, addr[31:24]);
          addr <= addr << 8;
          if (cnt == 3'(HASH_STEPS - 1)) begin
            cnt   <= '0;
            state <= F_MOD;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        F_MOD: begin
          r   <= mod_digit(r, h[31:28]);
          h   <= h << 4;
          cnt <= cnt + 3'd1;
          if (cnt == 3'(MOD_DIGITS - 1)) state <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ahbrl_queue.sv =====
// short queue of classified items between front and back
module ahbrl_queue import ahbrl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  input  entry_t push_entry,
  output logic   push_ready,
  output logic   pop_valid,
  output entry_t pop_entry,
  input  logic   pop
);

  `include "adaptive_hash_bucket_rate_limiter_defines.svh"

  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign push_ok    = push_valid && push_ready;
  assign pop_ok     = pop && pop_valid;

  // slot storage
  always_ff @(posedge clk) begin
    if (push_ok) slots[wr_ptr] <= push_entry;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop_ok)  rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push_ok && !pop_ok)      count <= count + 1'b1;
      else if (pop_ok && !push_ok) count <= count - 1'b1;
    end
  end

  `AHBRL_ASSERT_ALWAYS(a_queue_bound, count <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
  `AHBRL_ASSERT_NEXT(a_queue_grow, push_ok && !pop_ok, count == $past(count) + 1'b1, "queue count did not grow")

endmodule

// ===== rtl/ahbrl_back.sv =====
// back end: bucket state, window control, min/max search and result register
module ahbrl_back import ahbrl_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   q_valid,
  input  entry_t q_entry,
  output logic   q_pop,
  ahbrl_out_if.source res
);

  `include "adaptive_hash_bucket_rate_limiter_defines.svh"

  localparam int BW = $clog2(BUCKETS);
  localparam int CW = $clog2(BUCKETS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_HIT   = 3'd3;
  localparam logic [2:0] S_BUMP  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_CLOSE  = 2'd1;
  localparam logic [1:0] MODE_REOPEN = 2'd2;

  logic [2:0]         state;
  entry_t             cur;
  logic [1:0]         mode;
  logic [1:0]         verdict;
  logic [BUCKETS-1:0] open_vec;
  logic [BUCKETS-1:0] hvalid;
  logic [15:0]        hits_mem [BUCKETS];
  logic [15:0]        rd_data;
  logic [BW-1:0]      rd_addr;
  logic [LEVEL_W-1:0] level;
  logic [15:0]        replies;
  logic [31:0]        wstart;
  logic [31:0]        acc_total;
  logic [31:0]        rej_total;
  logic               found;
  logic [15:0]        best;
  logic [BW-1:0]      pick;
  logic [CW-1:0]      scan_cnt;
  logic [BW-1:0]      eval_idx;
  logic               res_valid;

  logic [32:0]   wend;
  logic [32:0]   now33;
  logic [1:0]    d_mode;
  logic [2:0]    d_next;
  logic [1:0]    d_verdict;
  logic [15:0]   e_hits;
  logic          e_cand;
  logic          e_better;
  logic          e_take;
  logic [BW-1:0] b_idx;
  logic [15:0]   b_hits;
  logic [15:0]   b_sat;
  logic          b_reject;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign res.valid = res_valid;
  assign b_idx     = cur.bucket[BW-1:0];

  // classify the item at the queue head
  assign wend  = {1'b0, wstart} + {17'd0, cfg.window_length};
  assign now33 = {1'b0, q_entry.current_time};

  always_comb begin
    d_mode    = MODE_NONE;
    d_next    = S_OUT;
    d_verdict = VERDICT_TICK;
    if (q_entry.command == CMD_TICK) begin
      if (wend < now33) begin
        if (replies < cfg.request_limit && level != '0) begin
          d_mode = MODE_REOPEN;
          d_next = S_SCAN;
        end else begin
          d_next = S_APPLY;
        end
      end
    end else if (!cfg.serve_public && !q_entry.private_signed) begin
      d_verdict = VERDICT_DROP;
    end else begin
      d_verdict = VERDICT_REPLY;
      d_next    = S_HIT;
      if (!q_entry.private_signed && replies > cfg.request_limit) begin
        d_next = S_APPLY;
        if (wend > now33) begin
          if (level < LEVEL_W'(BUCKETS)) begin
            d_mode = MODE_CLOSE;
            d_next = S_SCAN;
          end
        end else if (level != '0) begin
          d_mode = MODE_REOPEN;
          d_next = S_SCAN;
        end
      end
    end
  end

  // search step: busiest open or quietest closed, lowest index wins ties
  assign e_hits   = hvalid[eval_idx] ? rd_data : 16'd0;
  assign e_cand   = (mode == MODE_CLOSE) ? open_vec[eval_idx] : !open_vec[eval_idx];
  assign e_better = !found || ((mode == MODE_CLOSE) ? (e_hits > best) : (e_hits < best));
  assign e_take   = (state == S_SCAN) && (scan_cnt != '0) && e_cand && e_better;

  // hit update of the request's own bucket
  assign b_hits   = hvalid[b_idx] ? rd_data : 16'd0;
  assign b_sat    = (&b_hits) ? b_hits : b_hits + 16'd1;
  assign b_reject = !cur.private_signed && (level != '0) && !open_vec[b_idx];

  // memory read address: walk during the search, else the item's bucket
  always_comb begin
    if (state == S_SCAN && scan_cnt < CW'(BUCKETS)) rd_addr = scan_cnt[BW-1:0];
    else rd_addr = b_idx;
  end

  // hit count memory
  always_ff @(posedge clk) begin
    if (state == S_BUMP) hits_mem[b_idx] <= b_sat;
    rd_data <= hits_mem[rd_addr];
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      open_vec  <= '1;
      hvalid    <= '0;
      level     <= '0;
      replies   <= '0;
      wstart    <= '0;
      acc_total <= '0;
      rej_total <= '0;
      res_valid <= 1'b0;
      found     <= 1'b0;
      mode      <= MODE_NONE;
      scan_cnt  <= '0;
    end else begin
      if (res_valid && res.ready && state != S_OUT) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur      <= q_entry;
            mode     <= d_mode;
            verdict  <= d_verdict;
            found    <= 1'b0;
            best     <= '0;
            pick     <= '0;
            scan_cnt <= '0;
            eval_idx <= '0;
            state    <= d_next;
          end
        end
        S_SCAN: begin
          if (e_take) begin
            found <= 1'b1;
            best  <= e_hits;
            pick  <= eval_idx;
          end
          eval_idx <= scan_cnt[BW-1:0];
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == CW'(BUCKETS)) state <= S_APPLY;
        end
        S_APPLY: begin
          if (found) begin
            open_vec[pick] <= (mode == MODE_REOPEN);
            level <= (mode == MODE_CLOSE) ? level + 1'b1 : level - 1'b1;
          end
          hvalid  <= '0;
          replies <= '0;
          wstart  <= cur.current_time;
          state   <= (cur.command == CMD_TICK) ? S_OUT : S_HIT;
        end
        S_HIT: begin
          state <= S_BUMP;
        end
        S_BUMP: begin
          hvalid[b_idx] <= 1'b1;
          if (b_reject) begin
            if (!(&rej_total)) rej_total <= rej_total + 32'd1;
            verdict <= VERDICT_REJECT;
          end else begin
            if (!cur.private_signed) begin
              if (!(&replies))   replies   <= replies + 16'd1;
              if (!(&acc_total)) acc_total <= acc_total + 32'd1;
            end
            verdict <= VERDICT_REPLY;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid || res.ready) begin
            res_valid                <= 1'b1;
            res.verdict              <= verdict;
            res.bucket_index         <= cur.bucket;
            res.current_reject_level <= level;
            res.window_count         <= replies;
            res.accepted_count       <= acc_total;
            res.rejected_count       <= rej_total;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AHBRL_ASSERT_ALWAYS(a_level_matches, $countones(~open_vec) == level, "reject level off")
  `AHBRL_ASSERT_NEXT(a_apply_moves_level, state == S_APPLY && found, level != $past(level), "level stuck")

endmodule
